// File: hdl/nsfs_pkg.sv
`default_nettype none

package nsfs_pkg;

    // Sizes of the header store and the field counters.
    localparam int HEADER_LEN = 8;
    localparam int MAX_FIELD  = 31;
    localparam int HDR_LEN_W  = $clog2(HEADER_LEN + 1);
    localparam int HDR_IDX_W  = $clog2(HEADER_LEN);
    localparam int FIELD_W    = $clog2(MAX_FIELD + 1);

    // Fixed widths of the payload words.
    localparam int BYTE_W = 8;
    localparam int KIND_W = 3;
    localparam int FNUM_W = 5;

    // Characters with a meaning of their own.
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;

    // Sentence types, in search order after the unknown code.
    typedef enum logic [KIND_W-1:0] {
        KIND_UNKNOWN = 3'd0,
        KIND_RMC     = 3'd1,
        KIND_GGA     = 3'd2,
        KIND_GSA     = 3'd3,
        KIND_GSV     = 3'd4,
        KIND_VTG     = 3'd5,
        KIND_GLL     = 3'd6,
        KIND_RTK     = 3'd7
    } kind_t;

    localparam int KIND_COUNT = 7;
    localparam int TAG_MAX    = 6;

    typedef logic [BYTE_W-1:0] hdr_arr_t [HEADER_LEN];

    // Header tags, padded with zeros past their length.
    localparam logic [BYTE_W-1:0] TAG_CHARS [KIND_COUNT][TAG_MAX] = '{
        '{"R", "M", "C", 8'd0, 8'd0, 8'd0},
        '{"G", "G", "A", 8'd0, 8'd0, 8'd0},
        '{"G", "S", "A", 8'd0, 8'd0, 8'd0},
        '{"G", "S", "V", 8'd0, 8'd0, 8'd0},
        '{"V", "T", "G", 8'd0, 8'd0, 8'd0},
        '{"G", "L", "L", 8'd0, 8'd0, 8'd0},
        '{"$", "W", "T", "R", "T", "K"}
    };
    localparam int TAG_LEN [KIND_COUNT] = '{3, 3, 3, 3, 3, 3, 6};

    // Search the kept header bytes for each tag; the earliest tag in the list wins.
    function automatic kind_t classify(input hdr_arr_t hdr, input logic [HDR_LEN_W-1:0] hlen);
        kind_t kind;
        logic  hit;
        logic  ok;
        kind = KIND_UNKNOWN;
        for (int t = KIND_COUNT - 1; t >= 0; t--)
        begin
            hit = 1'b0;
            for (int s = 0; s < HEADER_LEN; s++)
            begin
                if (s + TAG_LEN[t] <= int'(hlen))
                begin
                    ok = 1'b1;
                    for (int k = 0; k < TAG_MAX; k++)
                    begin
                        if (k < TAG_LEN[t] && s + k < HEADER_LEN)
                        begin
                            if (hdr[s + k] != TAG_CHARS[t][k])
                            begin
                                ok = 1'b0;
                            end
                        end
                    end
                    hit = hit | ok;
                end
            end
            if (hit)
            begin
                kind = kind_t'(KIND_W'(t + 1));
            end
        end
        return kind;
    endfunction

    // Comma count that a complete sentence of each type reaches.
    function automatic logic [FIELD_W-1:0] min_commas(input kind_t kind);
        logic [FIELD_W-1:0] m;
        case (kind)
            KIND_RMC: m = FIELD_W'(12);
            KIND_GGA: m = FIELD_W'(12);
            KIND_GSA: m = FIELD_W'(18);
            KIND_GSV: m = FIELD_W'(8);
            KIND_VTG: m = FIELD_W'(9);
            KIND_GLL: m = FIELD_W'(7);
            KIND_RTK: m = FIELD_W'(11);
            default:  m = FIELD_W'(0);
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// File: hdl/nsfs_if.sv
`default_nettype none

// Input channel: one received character per word.
interface nsfs_in_if;
    logic                           valid;
    logic                           ready;
    logic [nsfs_pkg::BYTE_W-1:0]    rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Output channel: one field character, field end or line end per word.
interface nsfs_out_if;
    logic                           valid;
    logic                           ready;
    logic [nsfs_pkg::KIND_W-1:0]    sentence_kind;
    logic [nsfs_pkg::FNUM_W-1:0]    field_number;
    logic [nsfs_pkg::BYTE_W-1:0]    data_char;
    logic                           char_valid;
    logic                           field_end;
    logic                           line_end;
    logic                           line_complete;

    modport source (output valid, output sentence_kind, output field_number,
                    output data_char, output char_valid, output field_end,
                    output line_end, output line_complete, input ready);
    modport sink   (input valid, input sentence_kind, input field_number,
                    input data_char, input char_valid, input field_end,
                    input line_end, input line_complete, output ready);
endinterface

`default_nettype wire

// File: hdl/nmea_sentence_field_splitter_core.sv
// A result word is registered and valid on the output in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless stalled by the output; the line state updates in the
// accept cycle and the result sits in a single output register refilled in the cycle it is taken.
// Bytes that cause no result (header bytes, empty line ends, unknown sentences) go at the same rate.
// Reset (rst_n low, asynchronous) closes any open line and empties the output register.
`default_nettype none

module nmea_sentence_field_splitter_core
(
    input  wire           clk,
    input  wire           rst_n,
    nsfs_in_if.sink       in_ch,
    nsfs_out_if.source    out_ch
);

    localparam int FIELD_W   = nsfs_pkg::FIELD_W;
    localparam int HDR_LEN_W = nsfs_pkg::HDR_LEN_W;
    localparam int HDR_IDX_W = nsfs_pkg::HDR_IDX_W;

    // Line state.
    logic                         in_line_reg,       in_line_next;
    nsfs_pkg::hdr_arr_t           header_chars_reg,  header_chars_next;
    logic [HDR_LEN_W-1:0]         header_length_reg, header_length_next;
    nsfs_pkg::kind_t              current_kind_reg,  current_kind_next;
    logic [FIELD_W-1:0]           field_counter_reg, field_counter_next;
    logic [FIELD_W-1:0]           comma_total_reg,   comma_total_next;

    // Output register.
    logic                             out_valid_reg,  out_valid_next;
    nsfs_pkg::kind_t                  out_kind_reg,   out_kind_next;
    logic [nsfs_pkg::FNUM_W-1:0]      out_fnum_reg,   out_fnum_next;
    logic [nsfs_pkg::BYTE_W-1:0]      out_char_reg,   out_char_next;
    logic                             out_cv_reg,     out_cv_next;
    logic                             out_fe_reg,     out_fe_next;
    logic                             out_le_reg,     out_le_next;
    logic                             out_lc_reg,     out_lc_next;

    logic                         in_fire;
    logic [nsfs_pkg::BYTE_W-1:0]  b;
    logic                         is_eol;
    logic                         is_comma;
    logic [HDR_LEN_W-1:0]         eff_hlen;
    nsfs_pkg::kind_t              eff_kind;
    logic [FIELD_W-1:0]           eff_fc;
    logic [FIELD_W-1:0]           eff_ct;
    nsfs_pkg::kind_t              kind_now;
    nsfs_pkg::kind_t              line_kind;
    logic                         emit;

    // The output register can take a new word when empty or being drained.
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign b           = in_ch.rx_byte;
    assign is_eol      = (b == nsfs_pkg::CHAR_CR) || (b == nsfs_pkg::CHAR_LF);
    assign is_comma    = (b == nsfs_pkg::CHAR_COMMA);

    // A byte outside a line sees the state of a freshly opened line.
    assign eff_hlen = in_line_reg ? header_length_reg : '0;
    assign eff_kind = in_line_reg ? current_kind_reg  : nsfs_pkg::KIND_UNKNOWN;
    assign eff_fc   = in_line_reg ? field_counter_reg : '0;
    assign eff_ct   = in_line_reg ? comma_total_reg   : '0;
    assign kind_now = nsfs_pkg::classify(header_chars_reg, eff_hlen);
    assign line_kind = (eff_fc == '0) ? kind_now : eff_kind;

    // Per-byte update of the line state and the result word.
    always_comb
    begin
        in_line_next       = in_line_reg;
        header_chars_next  = header_chars_reg;
        header_length_next = header_length_reg;
        current_kind_next  = current_kind_reg;
        field_counter_next = field_counter_reg;
        comma_total_next   = comma_total_reg;

        emit          = 1'b0;
        out_kind_next = eff_kind;
        out_fnum_next = eff_fc[nsfs_pkg::FNUM_W-1:0];
        out_char_next = '0;
        out_cv_next   = 1'b0;
        out_fe_next   = 1'b0;
        out_le_next   = 1'b0;
        out_lc_next   = 1'b0;

        if (in_fire)
        begin
            if (is_eol)
            begin
                if (in_line_reg)
                begin
                    emit          = 1'b1;
                    out_kind_next = line_kind;
                    out_le_next   = 1'b1;
                    out_lc_next   = (line_kind != nsfs_pkg::KIND_UNKNOWN) &&
                                    (eff_ct >= nsfs_pkg::min_commas(line_kind));
                    in_line_next       = 1'b0;
                    header_length_next = '0;
                    current_kind_next  = nsfs_pkg::KIND_UNKNOWN;
                    field_counter_next = '0;
                    comma_total_next   = '0;
                end
            end
            else
            begin
                in_line_next       = 1'b1;
                header_length_next = eff_hlen;
                current_kind_next  = eff_kind;
                field_counter_next = eff_fc;
                comma_total_next   = eff_ct;
                if (eff_fc == '0)
                begin
                    // Header: the first comma classifies, other bytes are kept while the store has room.
                    if (is_comma)
                    begin
                        current_kind_next  = kind_now;
                        field_counter_next = FIELD_W'(1);
                        comma_total_next   = FIELD_W'(1);
                    end
                    else if (int'(eff_hlen) < nsfs_pkg::HEADER_LEN)
                    begin
                        for (int i = 0; i < nsfs_pkg::HEADER_LEN; i++)
                        begin
                            if (eff_hlen[HDR_IDX_W-1:0] == HDR_IDX_W'(i))
                            begin
                                header_chars_next[i] = b;
                            end
                        end
                        header_length_next = eff_hlen + HDR_LEN_W'(1);
                    end
                end
                else if (is_comma)
                begin
                    // Field end: both counters saturate.
                    if (int'(eff_ct) < nsfs_pkg::MAX_FIELD)
                    begin
                        comma_total_next = eff_ct + FIELD_W'(1);
                    end
                    if (int'(eff_fc) < nsfs_pkg::MAX_FIELD)
                    begin
                        field_counter_next = eff_fc + FIELD_W'(1);
                    end
                    emit        = (eff_kind != nsfs_pkg::KIND_UNKNOWN);
                    out_fe_next = 1'b1;
                end
                else
                begin
                    emit          = (eff_kind != nsfs_pkg::KIND_UNKNOWN);
                    out_char_next = b;
                    out_cv_next   = 1'b1;
                end
            end
        end

        // Output word valid: loaded on accept, dropped once taken.
        if (in_fire)
        begin
            out_valid_next = emit;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_line_reg       <= 1'b0;
            header_length_reg <= '0;
            current_kind_reg  <= nsfs_pkg::KIND_UNKNOWN;
            field_counter_reg <= '0;
            comma_total_reg   <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            in_line_reg       <= in_line_next;
            header_length_reg <= header_length_next;
            current_kind_reg  <= current_kind_next;
            field_counter_reg <= field_counter_next;
            comma_total_reg   <= comma_total_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Header bytes and result payload.
    always_ff @(posedge clk)
    begin
        header_chars_reg <= header_chars_next;
        if (in_fire)
        begin
            out_kind_reg <= out_kind_next;
            out_fnum_reg <= out_fnum_next;
            out_char_reg <= out_char_next;
            out_cv_reg   <= out_cv_next;
            out_fe_reg   <= out_fe_next;
            out_le_reg   <= out_le_next;
            out_lc_reg   <= out_lc_next;
        end
    end

    // Drive the output channel.
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.sentence_kind = out_kind_reg;
    assign out_ch.field_number  = out_fnum_reg;
    assign out_ch.data_char     = out_char_reg;
    assign out_ch.char_valid    = out_cv_reg;
    assign out_ch.field_end     = out_fe_reg;
    assign out_ch.line_end      = out_le_reg;
    assign out_ch.line_complete = out_lc_reg;

`ifndef NO_ASSERTIONS
    // With no line open, every counter is back at zero.
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !in_line_reg |-> (field_counter_reg == '0 && comma_total_reg == '0 &&
                          header_length_reg == '0))
        else $error("line state not cleared outside a line");

    // Field and comma counters advance together.
    a_counters_agree: assert property (@(posedge clk) disable iff (!rst_n)
        comma_total_reg == field_counter_reg)
        else $error("comma total and field counter diverged");

    // An accepted line end always closes the line.
    a_eol_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_eol) |=> !in_line_reg)
        else $error("line still open after a line end");

    // A byte result only appears for a known sentence inside a data field.
    a_char_known: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_cv_reg) |->
            (out_kind_reg != nsfs_pkg::KIND_UNKNOWN && out_fnum_reg != '0 &&
             !out_fe_reg && !out_le_reg))
        else $error("byte result with unknown kind or wrong flags");

    // The header store never counts past its size.
    a_hlen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(header_length_reg) <= nsfs_pkg::HEADER_LEN)
        else $error("header length overran the header store");
`endif

endmodule

`default_nettype wire

// File: sim/tb_nmea_sentence_field_splitter_core.sv
module tb_nmea_sentence_field_splitter_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_W     = nsfs_pkg::BYTE_W;
    localparam int KIND_W     = nsfs_pkg::KIND_W;
    localparam int FNUM_W     = nsfs_pkg::FNUM_W;
    localparam int HEADER_LEN = nsfs_pkg::HEADER_LEN;
    localparam int MAX_FIELD  = nsfs_pkg::MAX_FIELD;
    localparam int KIND_COUNT = nsfs_pkg::KIND_COUNT;

    typedef nsfs_pkg::kind_t kind_t;

    localparam int RANDOM_BYTES = 1700;
    localparam int OPENING_ROWS = 26;
    localparam int FIFO_DEPTH   = 48;

    // One output word as the splitter presents it.
    typedef struct packed {
        kind_t              kind;
        logic [FNUM_W-1:0]  fnum;
        logic [BYTE_W-1:0]  ch;
        logic               ch_ok;
        logic               fend;
        logic               lend;
        logic               lcomp;
    } split_word_t;

    // One received byte, with an optional hand-written expectation.
    typedef struct packed {
        logic [BYTE_W-1:0]  rx;
        logic               typed;
        logic               has_word;
        split_word_t        word;
    } rx_item_t;

    localparam split_word_t NO_WORD = '0;

    // Opening sequence: an empty line, a short sentence with the byte extremes,
    // a line that holds a header only, and an unknown sentence whose tag falls
    // past the kept part of a long header.
    localparam rx_item_t OPENING_BYTES [OPENING_ROWS] = '{
        {nsfs_pkg::CHAR_CR,    1'b1, 1'b0, NO_WORD},
        {"$",                  1'b0, 1'b0, NO_WORD},
        {"G",                  1'b0, 1'b0, NO_WORD},
        {"S",                  1'b0, 1'b0, NO_WORD},
        {"V",                  1'b0, 1'b0, NO_WORD},
        {nsfs_pkg::CHAR_COMMA, 1'b0, 1'b0, NO_WORD},
        {8'hFF,                1'b1, 1'b1,
            {nsfs_pkg::KIND_GSV, 5'd1, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0}},
        {8'h00,                1'b1, 1'b1,
            {nsfs_pkg::KIND_GSV, 5'd1, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0}},
        {nsfs_pkg::CHAR_COMMA, 1'b1, 1'b1,
            {nsfs_pkg::KIND_GSV, 5'd1, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0}},
        {nsfs_pkg::CHAR_CR,    1'b1, 1'b1,
            {nsfs_pkg::KIND_GSV, 5'd2, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0}},
        {"V",                  1'b0, 1'b0, NO_WORD},
        {"T",                  1'b0, 1'b0, NO_WORD},
        {"G",                  1'b0, 1'b0, NO_WORD},
        {nsfs_pkg::CHAR_LF,    1'b1, 1'b1,
            {nsfs_pkg::KIND_VTG, 5'd0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0}},
        {"A",                  1'b0, 1'b0, NO_WORD},
        {"B",                  1'b0, 1'b0, NO_WORD},
        {"C",                  1'b0, 1'b0, NO_WORD},
        {"D",                  1'b0, 1'b0, NO_WORD},
        {"E",                  1'b0, 1'b0, NO_WORD},
        {"F",                  1'b0, 1'b0, NO_WORD},
        {"R",                  1'b0, 1'b0, NO_WORD},
        {"M",                  1'b0, 1'b0, NO_WORD},
        {"C",                  1'b0, 1'b0, NO_WORD},
        {nsfs_pkg::CHAR_COMMA, 1'b0, 1'b0, NO_WORD},
        {"Z",                  1'b1, 1'b0, NO_WORD},
        {nsfs_pkg::CHAR_LF,    1'b1, 1'b1,
            {nsfs_pkg::KIND_UNKNOWN, 5'd1, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0}}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    nsfs_in_if  in_ch ();
    nsfs_out_if out_ch ();

    nmea_sentence_field_splitter_core dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Line state of the splitter as the testbench tracks it.
    logic               ln_open   = 1'b0;
    logic [BYTE_W-1:0]  hdr_bytes [HEADER_LEN];
    int                 hdr_fill  = 0;
    kind_t              ln_kind   = nsfs_pkg::KIND_UNKNOWN;
    int                 fld_idx   = 0;
    int                 comma_cnt = 0;

    split_word_t        pending_words [$];
    rx_item_t           rx_fifo [$];
    int                 queued_total = 0;
    int                 miss_count   = 0;
    int                 send_idle    = 15;
    int                 recv_idle    = 46;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Tags, left aligned in six bytes.
    function automatic logic [47:0] tag_text(input kind_t k);
        case (k)
            nsfs_pkg::KIND_RMC: tag_text = {"RMC", 24'd0};
            nsfs_pkg::KIND_GGA: tag_text = {"GGA", 24'd0};
            nsfs_pkg::KIND_GSA: tag_text = {"GSA", 24'd0};
            nsfs_pkg::KIND_GSV: tag_text = {"GSV", 24'd0};
            nsfs_pkg::KIND_VTG: tag_text = {"VTG", 24'd0};
            nsfs_pkg::KIND_GLL: tag_text = {"GLL", 24'd0};
            nsfs_pkg::KIND_RTK: tag_text = {"$W", "TRTK"};
            default:            tag_text = '0;
        endcase
    endfunction

    function automatic int tag_size(input kind_t k);
        return (k == nsfs_pkg::KIND_RTK) ? 6 : 3;
    endfunction

    function automatic int needed_commas(input kind_t k);
        case (k)
            nsfs_pkg::KIND_RMC: return 12;
            nsfs_pkg::KIND_GGA: return 12;
            nsfs_pkg::KIND_GSA: return 18;
            nsfs_pkg::KIND_GSV: return 8;
            nsfs_pkg::KIND_VTG: return 9;
            nsfs_pkg::KIND_GLL: return 7;
            nsfs_pkg::KIND_RTK: return 11;
            default:            return 0;
        endcase
    endfunction

    // Search the kept header bytes for each tag; the first tag in type order wins.
    function automatic kind_t header_kind();
        kind_t       k;
        logic [47:0] tag;
        int          n;
        logic        hit;
        for (int t = 1; t <= KIND_COUNT; t++)
        begin
            k   = kind_t'(KIND_W'(t));
            tag = tag_text(k);
            n   = tag_size(k);
            for (int s = 0; s + n <= hdr_fill; s++)
            begin
                hit = 1'b1;
                for (int i = 0; i < n; i++)
                begin
                    if (hdr_bytes[s + i] != tag[47 - 8 * i -: 8])
                        hit = 1'b0;
                end
                if (hit)
                    return k;
            end
        end
        return nsfs_pkg::KIND_UNKNOWN;
    endfunction

    // Advance the line state by one accepted byte and queue the word it causes.
    task automatic track_byte(input rx_item_t item);
        split_word_t w;
        logic        made;
        int          closed;
        w    = NO_WORD;
        made = 1'b0;
        if (item.rx == nsfs_pkg::CHAR_CR || item.rx == nsfs_pkg::CHAR_LF)
        begin
            // A line end with no open line is an empty line and vanishes.
            if (ln_open)
            begin
                if (fld_idx == 0)
                    ln_kind = header_kind();
                w.kind  = ln_kind;
                w.fnum  = FNUM_W'(fld_idx);
                w.lend  = 1'b1;
                w.lcomp = (ln_kind != nsfs_pkg::KIND_UNKNOWN) &&
                          (comma_cnt >= needed_commas(ln_kind));
                made    = 1'b1;
                ln_open   = 1'b0;
                hdr_fill  = 0;
                ln_kind   = nsfs_pkg::KIND_UNKNOWN;
                fld_idx   = 0;
                comma_cnt = 0;
            end
        end
        else
        begin
            if (!ln_open)
            begin
                ln_open   = 1'b1;
                hdr_fill  = 0;
                ln_kind   = nsfs_pkg::KIND_UNKNOWN;
                fld_idx   = 0;
                comma_cnt = 0;
            end
            if (fld_idx == 0)
            begin
                // Header bytes are stored silently; the first comma classifies them.
                if (item.rx == nsfs_pkg::CHAR_COMMA)
                begin
                    ln_kind   = header_kind();
                    fld_idx   = 1;
                    comma_cnt = 1;
                end
                else if (hdr_fill < HEADER_LEN)
                begin
                    hdr_bytes[hdr_fill] = item.rx;
                    hdr_fill++;
                end
            end
            else if (item.rx == nsfs_pkg::CHAR_COMMA)
            begin
                closed = fld_idx;
                if (comma_cnt < MAX_FIELD)
                    comma_cnt++;
                if (fld_idx < MAX_FIELD)
                    fld_idx++;
                if (ln_kind != nsfs_pkg::KIND_UNKNOWN)
                begin
                    w.kind = ln_kind;
                    w.fnum = FNUM_W'(closed);
                    w.fend = 1'b1;
                    made   = 1'b1;
                end
            end
            else if (ln_kind != nsfs_pkg::KIND_UNKNOWN)
            begin
                w.kind  = ln_kind;
                w.fnum  = FNUM_W'(fld_idx);
                w.ch    = item.rx;
                w.ch_ok = 1'b1;
                made    = 1'b1;
            end
        end
        // A hand-written row states its own expectation; the state above still advances.
        if (item.typed)
        begin
            made = item.has_word;
            w    = item.word;
        end
        if (made)
            pending_words.push_back(w);
    endtask

    task automatic push_rx(input logic [BYTE_W-1:0] b);
        rx_fifo.push_back({b, 1'b0, 1'b0, NO_WORD});
        queued_total++;
    endtask

    task automatic push_tag(input kind_t k);
        logic [47:0] tag;
        tag = tag_text(k);
        for (int i = 0; i < tag_size(k); i++)
            push_rx(tag[47 - 8 * i -: 8]);
    endtask

    // A field byte: mostly printable, sometimes any byte but a comma or line end.
    function automatic logic [BYTE_W-1:0] field_byte();
        logic [BYTE_W-1:0] b;
        do
            b = ($urandom_range(9) < 7) ? BYTE_W'($urandom_range(126, 32))
                                        : BYTE_W'($urandom_range(255, 0));
        while (b == nsfs_pkg::CHAR_CR || b == nsfs_pkg::CHAR_LF ||
               b == nsfs_pkg::CHAR_COMMA);
        return b;
    endfunction

    task automatic push_line_end();
        case ($urandom_range(2))
            0:
            begin
                push_rx(nsfs_pkg::CHAR_CR);
                push_rx(nsfs_pkg::CHAR_LF);
            end
            1:       push_rx(nsfs_pkg::CHAR_LF);
            default: push_rx(nsfs_pkg::CHAR_CR);
        endcase
    endtask

    // One random line: mostly proper sentences, the rest raw noise and broken lines.
    task automatic queue_random_line();
        int    pick;
        int    kind_pick;
        int    commas;
        int    need;
        pick = $urandom_range(99);
        if (pick < 72)
        begin
            kind_pick = $urandom_range(7);
            if (kind_pick == 7)
            begin
                push_tag(nsfs_pkg::KIND_RTK);
            end
            else
            begin
                if ($urandom_range(5) != 0)
                    push_rx("$");
                case ($urandom_range(3))
                    0:
                    begin
                        push_rx("G");
                        push_rx("P");
                    end
                    1:
                    begin
                        push_rx("G");
                        push_rx("N");
                    end
                    default:
                    begin
                        push_rx(BYTE_W'($urandom_range("Z", "A")));
                        push_rx(BYTE_W'($urandom_range("Z", "A")));
                    end
                endcase
                if (kind_pick == 0)
                begin
                    repeat (3)
                        push_rx(BYTE_W'($urandom_range("Z", "A")));
                end
                else
                    push_tag(kind_t'(KIND_W'(kind_pick)));
            end
            // Comma counts sit around the type minimum, now and then around or past saturation.
            if (kind_pick == 0)
                commas = $urandom_range(14);
            else if ($urandom_range(9) == 0)
                commas = $urandom_range(40, 30);
            else
            begin
                need   = needed_commas(kind_t'(KIND_W'(kind_pick)));
                commas = $urandom_range(need + 2, need - 2);
            end
            for (int i = 0; i < commas; i++)
            begin
                push_rx(nsfs_pkg::CHAR_COMMA);
                repeat ($urandom_range(3))
                    push_rx(field_byte());
            end
            push_line_end();
        end
        else if (pick < 86)
        begin
            repeat ($urandom_range(8, 1))
                push_rx(BYTE_W'($urandom_range(255, 0)));
        end
        else
        begin
            // Broken line: long or crowded header, a few fields, an early end.
            repeat ($urandom_range(10))
                push_rx(field_byte());
            repeat ($urandom_range(2))
                push_tag(kind_t'(KIND_W'($urandom_range(KIND_COUNT, 1))));
            repeat ($urandom_range(4))
            begin
                push_rx(nsfs_pkg::CHAR_COMMA);
                push_rx(field_byte());
            end
            push_line_end();
            if ($urandom_range(3) == 0)
                push_line_end();
        end
    endtask

    task automatic note_miss(input string what, input split_word_t want,
                             input split_word_t got);
        miss_count++;
        if (miss_count <= 10)
        begin
            $display("%0t: %s: expected kind %0d field %0d char %02h cv %b fe %b le %b lc %b",
                     $realtime, what, want.kind, want.fnum, want.ch, want.ch_ok,
                     want.fend, want.lend, want.lcomp);
            $display("%0t: %s: actual   kind %0d field %0d char %02h cv %b fe %b le %b lc %b",
                     $realtime, what, got.kind, got.fnum, got.ch, got.ch_ok,
                     got.fend, got.lend, got.lcomp);
        end
    endtask

    // Byte sender: holds each word until it is taken, idles at random between words.
    initial
    begin : byte_source
        logic taken;
        in_ch.valid   <= 1'b0;
        in_ch.rx_byte <= '0;
        forever
        begin
            @(posedge clk);
            taken = in_ch.valid && in_ch.ready;
            if (taken)
                track_byte(rx_fifo.pop_front());
            if (!in_ch.valid || taken)
            begin
                if (rst_n && rx_fifo.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    in_ch.valid   <= 1'b1;
                    in_ch.rx_byte <= rx_fifo[0].rx;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Word receiver: checks every taken word against the oldest expectation.
    initial
    begin : word_sink
        split_word_t got;
        split_word_t want;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                got.kind  = kind_t'(out_ch.sentence_kind);
                got.fnum  = out_ch.field_number;
                got.ch    = out_ch.data_char;
                got.ch_ok = out_ch.char_valid;
                got.fend  = out_ch.field_end;
                got.lend  = out_ch.line_end;
                got.lcomp = out_ch.line_complete;
                if (pending_words.size() == 0)
                    note_miss("word with nothing expected", NO_WORD, got);
                else
                begin
                    want = pending_words.pop_front();
                    if (got.kind !== want.kind || got.fnum !== want.fnum ||
                        got.ch !== want.ch || got.ch_ok !== want.ch_ok ||
                        got.fend !== want.fend || got.lend !== want.lend ||
                        got.lcomp !== want.lcomp)
                        note_miss("word mismatch", want, got);
                end
            end
            out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle);
        end
    end

    // Stimulus: opening table, then three random phases with different idling.
    initial
    begin : stimulus
        int phase_start;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < OPENING_ROWS; i++)
            rx_fifo.push_back(OPENING_BYTES[i]);
        for (int p = 0; p < 3; p++)
        begin
            case (p)
                0:
                begin
                    send_idle = 15;
                    recv_idle = 46;
                end
                1:
                begin
                    send_idle = 46;
                    recv_idle = 15;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            phase_start = queued_total;
            while (queued_total - phase_start < RANDOM_BYTES / 3)
            begin
                while (rx_fifo.size() >= FIFO_DEPTH)
                    @(posedge clk);
                queue_random_line();
            end
        end
        while (rx_fifo.size() != 0 || in_ch.valid)
            @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (miss_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin : watchdog
        #(5_000_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: nmea_sentence_field_splitter_core.f
hdl/nsfs_pkg.sv
hdl/nsfs_if.sv
hdl/nmea_sentence_field_splitter_core.sv
sim/tb_nmea_sentence_field_splitter_core.sv
